FILE: rtl/cbs_pkg.sv
// shared types, codes and spline tables of the cubic b-spline sampler
package cbs_pkg;

    localparam int MAX_ROWS_DEF = 256;
    localparam int MAX_COLS_DEF = 256;
    // span for tap coordinate and image size compares, holds 4096
    localparam int CRD_W = 13;
    localparam int QUEUE_DEPTH = 2;

    typedef enum logic [1:0] {
        ACT_WRITE  = 2'd0,
        ACT_VALUE  = 2'd1,
        ACT_GRAD_X = 2'd2,
        ACT_GRAD_Y = 2'd3
    } action_t;

    localparam logic CFG_HEIGHT = 1'b0;
    localparam logic CFG_WIDTH  = 1'b1;

    typedef struct packed {
        action_t            action;
        logic [7:0]         pixel_row;
        logic [7:0]         pixel_col;
        logic signed [15:0] pixel_value;
        logic signed [8:0]  cr;
        logic signed [8:0]  fr;
        logic signed [8:0]  cc;
        logic signed [8:0]  fc;
    } cmd_t;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_TAPS,
        BK_FLUSH
    } bk_state_t;

    typedef logic [15:0] spl_tab_t [256];

    // q16 spline weight for |d| in 0..255 (hi = 0) or 256..511 (hi = 1)
    function automatic spl_tab_t build_spl(input logic hi);
        spl_tab_t t;
        longint   a;
        longint   w;
        for (int i = 0; i < 256; i++)
        begin
            a = hi ? longint'(i + 256) : longint'(i);
            if (!hi)
                w = 3 * a * a * a - 1536 * a * a + (longint'(4) << 24);
            else
                w = (512 - a) * (512 - a) * (512 - a);
            t[i] = 16'((w + 768) / 1536);
        end
        return t;
    endfunction

endpackage

FILE: rtl/cbs_front.sv
// front end: decodes a request and splits the query coordinates
module cbs_front
    import cbs_pkg::*;
(
    input  logic [1:0]         action,
    input  logic [7:0]         pixel_row,
    input  logic [7:0]         pixel_col,
    input  logic signed [15:0] pixel_value,
    input  logic signed [16:0] query_row,
    input  logic signed [16:0] query_col,
    output cmd_t               cmd
);

    // truncate toward zero: floor, then step up for a negative value with a fraction
    function automatic logic [17:0] split(input logic signed [16:0] q);
        logic              adj;
        logic signed [8:0] c;
        logic signed [8:0] f;
        adj = q[16] && (q[7:0] != 8'd0);
        c   = $signed(q[16:8]) + $signed({8'd0, adj});
        f   = adj ? $signed({1'b1, q[7:0]}) : $signed({1'b0, q[7:0]});
        return {c, f};
    endfunction

    logic [17:0] row_split;
    logic [17:0] col_split;

    assign row_split = split(query_row);
    assign col_split = split(query_col);

    always_comb
    begin
        cmd.action      = action_t'(action);
        cmd.pixel_row   = pixel_row;
        cmd.pixel_col   = pixel_col;
        cmd.pixel_value = pixel_value;
        cmd.cr          = $signed(row_split[17:9]);
        cmd.fr          = $signed(row_split[8:0]);
        cmd.cc          = $signed(col_split[17:9]);
        cmd.fc          = $signed(col_split[8:0]);
    end

endmodule

FILE: rtl/cbs_cmd_fifo.sv
// short request queue between front end and back end
module cbs_cmd_fifo
    import cbs_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  cmd_t push_cmd,
    input  logic pop,
    output cmd_t head,
    output logic full,
    output logic empty
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int NW = $clog2(DEPTH + 1);

    cmd_t          slot_reg [DEPTH];
    logic [PW-1:0] wp_reg;
    logic [PW-1:0] wp_next;
    logic [PW-1:0] rp_reg;
    logic [PW-1:0] rp_next;
    logic [NW-1:0] cnt_reg;
    logic [NW-1:0] cnt_next;

    assign full  = (cnt_reg == NW'(DEPTH));
    assign empty = (cnt_reg == '0);
    assign head  = slot_reg[rp_reg];

    always_comb
    begin
        wp_next  = wp_reg;
        rp_next  = rp_reg;
        cnt_next = cnt_reg;
        if (push)
            wp_next = (wp_reg == PW'(DEPTH - 1)) ? '0 : wp_reg + 1'b1;
        if (pop)
            rp_next = (rp_reg == PW'(DEPTH - 1)) ? '0 : rp_reg + 1'b1;
        if (push && !pop)
            cnt_next = cnt_reg + 1'b1;
        else if (pop && !push)
            cnt_next = cnt_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            wp_reg  <= wp_next;
            rp_reg  <= rp_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            slot_reg[wp_reg] <= push_cmd;
    end

endmodule

FILE: rtl/cbs_back.sv
// back end: pixel memory, tap sequencer, weight and accumulate pipeline
module cbs_back
    import cbs_pkg::*;
#(
    parameter int MAX_ROWS = MAX_ROWS_DEF,
    parameter int MAX_COLS = MAX_COLS_DEF
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  cmd_t               head,
    input  logic               empty,
    input  logic [8:0]         height,
    input  logic [8:0]         width,
    output logic               pop,
    output logic signed [39:0] sample_result,
    output logic               done
);

    localparam int RW = $clog2(MAX_ROWS);
    localparam int CW = $clog2(MAX_COLS);
    localparam int AW = RW + CW;
    localparam spl_tab_t SPL_LO = build_spl(1'b0);
    localparam spl_tab_t SPL_HI = build_spl(1'b1);

    function automatic logic [9:0] mag(input logic signed [10:0] d);
        logic [10:0] n;
        n = d[10] ? 11'(-d) : 11'(d);
        return n[9:0];
    endfunction

    function automatic logic signed [18:0] spline(input logic signed [10:0] d);
        logic [9:0] a;
        a = mag(d);
        if (a < 10'd256)
            return $signed({3'd0, SPL_LO[a[7:0]]});
        else if (a < 10'd512)
            return $signed({3'd0, SPL_HI[a[7:0]]});
        else
            return '0;
    endfunction

    // odd function of d, q17
    function automatic logic signed [18:0] dspline(input logic signed [10:0] d);
        logic [9:0]         a;
        logic signed [11:0] k;
        logic [8:0]         t;
        logic signed [22:0] m;
        logic signed [18:0] e;
        a = mag(d);
        k = $signed({2'd0, a}) * 12'sd3 - 12'sd1024;
        t = 9'(10'd512 - a);
        if (a <= 10'd256)
        begin
            m = $signed({1'b0, a}) * k;
            e = 19'(m);
        end
        else if (a < 10'd512)
        begin
            m = $signed({14'd0, t}) * $signed({14'd0, t});
            e = -19'(m);
        end
        else
            e = '0;
        return d[10] ? -e : e;
    endfunction

    bk_state_t state_reg;
    bk_state_t state_next;
    logic [3:0] tap_reg;
    cmd_t       cur_reg;

    logic signed [15:0] mem [2**AW];
    logic [AW-1:0]      mem_addr;
    logic               mem_we;
    logic signed [15:0] pix_reg;

    logic [CRD_W-1:0] h_lim;
    logic [CRD_W-1:0] w_lim;
    logic [CRD_W-1:0] wr_row;
    logic [CRD_W-1:0] wr_col;
    logic             issue;
    logic             start_query;

    logic signed [2:0]  ro;
    logic signed [2:0]  co;
    logic signed [10:0] tr;
    logic signed [10:0] tc;
    logic signed [10:0] dr;
    logic signed [10:0] dc;
    logic [CRD_W-1:0]   tr_ext;
    logic [CRD_W-1:0]   tc_ext;
    logic               inr;
    logic signed [18:0] deriv;
    logic signed [18:0] wr;
    logic signed [18:0] wc;

    logic               v1_reg, last1_reg, inr1_reg;
    logic signed [18:0] wr1_reg, wc1_reg;
    logic               v2_reg, last2_reg;
    logic signed [35:0] w2_reg;
    logic signed [15:0] pix2_reg;
    logic               v3_reg, last3_reg;
    logic signed [51:0] prod3_reg;
    logic signed [55:0] acc_reg;
    logic               fin_reg;
    logic               done_reg;
    logic signed [39:0] res_reg;
    logic signed [55:0] rnd_val;
    logic signed [55:0] rnd_grad;

    assign h_lim = ({4'd0, height} > CRD_W'(MAX_ROWS)) ? CRD_W'(MAX_ROWS) : {4'd0, height};
    assign w_lim = ({4'd0, width} > CRD_W'(MAX_COLS)) ? CRD_W'(MAX_COLS) : {4'd0, width};

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            BK_IDLE:
                if (!empty && head.action != ACT_WRITE)
                    state_next = BK_TAPS;
            BK_TAPS:
                if (tap_reg == 4'd15)
                    state_next = BK_FLUSH;
            BK_FLUSH:
                if (fin_reg)
                    state_next = BK_IDLE;
            default:
                state_next = BK_IDLE;
        endcase
    end

    // outputs of the sequencer
    always_comb
    begin
        pop         = 1'b0;
        issue       = 1'b0;
        start_query = 1'b0;
        case (state_reg)
            BK_IDLE:
            begin
                pop         = !empty;
                start_query = !empty && (head.action != ACT_WRITE);
            end
            BK_TAPS:
                issue = 1'b1;
            BK_FLUSH:
                issue = 1'b0;
            default:
                pop = 1'b0;
        endcase
    end

    // tap position and weights
    assign wr_row = {5'd0, head.pixel_row};
    assign wr_col = {5'd0, head.pixel_col};
    assign mem_we = pop && (head.action == ACT_WRITE)
                    && (wr_row < CRD_W'(MAX_ROWS)) && (wr_col < CRD_W'(MAX_COLS));

    assign ro     = $signed({1'b0, tap_reg[3:2]}) - 3'sd1;
    assign co     = $signed({1'b0, tap_reg[1:0]}) - 3'sd1;
    assign tr     = 11'(cur_reg.cr) + 11'(ro);
    assign tc     = 11'(cur_reg.cc) + 11'(co);
    assign dr     = $signed({ro, 8'd0}) - 11'(cur_reg.fr);
    assign dc     = $signed({co, 8'd0}) - 11'(cur_reg.fc);
    assign tr_ext = CRD_W'(tr[9:0]);
    assign tc_ext = CRD_W'(tc[9:0]);
    assign inr    = !tr[10] && !tc[10] && (tr_ext < h_lim) && (tc_ext < w_lim);
    assign deriv  = dspline((cur_reg.action == ACT_GRAD_Y) ? dr : dc);
    assign wr     = (cur_reg.action == ACT_GRAD_Y) ? deriv : spline(dr);
    assign wc     = (cur_reg.action == ACT_GRAD_X) ? deriv : spline(dc);

    assign mem_addr = mem_we ? {wr_row[RW-1:0], wr_col[CW-1:0]}
                             : {tr_ext[RW-1:0], tc_ext[CW-1:0]};

    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[mem_addr] <= head.pixel_value;
        pix_reg <= mem[mem_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= BK_IDLE;
            tap_reg   <= '0;
            v1_reg    <= 1'b0;
            v2_reg    <= 1'b0;
            v3_reg    <= 1'b0;
            fin_reg   <= 1'b0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            tap_reg   <= issue ? tap_reg + 1'b1 : '0;
            v1_reg    <= issue;
            v2_reg    <= v1_reg;
            v3_reg    <= v2_reg;
            fin_reg   <= v3_reg && last3_reg;
            done_reg  <= fin_reg;
        end
    end

    assign rnd_val  = (acc_reg + 56'sd524288) >>> 20;
    assign rnd_grad = -((acc_reg + 56'sd1048576) >>> 21);

    always_ff @(posedge clk)
    begin
        if (start_query)
            cur_reg <= head;
        last1_reg <= (tap_reg == 4'd15);
        inr1_reg  <= inr;
        wr1_reg   <= wr;
        wc1_reg   <= wc;
        last2_reg <= last1_reg;
        w2_reg    <= 36'(wr1_reg * wc1_reg);
        pix2_reg  <= inr1_reg ? pix_reg : 16'sd0;
        last3_reg <= last2_reg;
        prod3_reg <= 52'(w2_reg * pix2_reg);
        if (start_query)
            acc_reg <= '0;
        else if (v3_reg)
            acc_reg <= acc_reg + 56'(prod3_reg);
        if (fin_reg)
            res_reg <= (cur_reg.action == ACT_VALUE) ? 40'(rnd_val) : 40'(rnd_grad);
    end

    assign sample_result = res_reg;
    assign done          = done_reg;

endmodule

FILE: rtl/cubic_bspline_subpixel_sampler.sv
// top level of the cubic b-spline sub-pixel sampler
//
// A request is taken at a clock edge where start is high and busy is low.
// A pixel write is stored when the back end pops it from the queue and
// returns nothing. A query (value, x gradient or y gradient) walks its
// sixteen 4x4 taps through the single-port pixel memory at one tap per
// cycle, so a query occupies the back end while it is picked up, through its
// sixteen memory reads, and while the weight-multiply-accumulate pipeline
// drains and the result is rounded. done rises in the cycle after that,
// which is also the first cycle the back end can pick up the next request.
// The result shows on sample_result for exactly one cycle with done high;
// there is no way to hold it, so the receiver must take it then. A
// two-entry queue lets the front end take requests while a query is in
// progress; busy is high while it is full.
// Pixels are not cleared at reset, so only query regions that were written.
// image_height and image_width are written through cfg_we/cfg_index/cfg_data,
// which the user must do while no request is in flight; the block does not check.
module cubic_bspline_subpixel_sampler
    import cbs_pkg::*;
#(
    parameter int MAX_ROWS = MAX_ROWS_DEF,
    parameter int MAX_COLS = MAX_COLS_DEF
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [1:0]         action,
    input  logic [7:0]         pixel_row,
    input  logic [7:0]         pixel_col,
    input  logic signed [15:0] pixel_value,
    input  logic signed [16:0] query_row,
    input  logic signed [16:0] query_col,
    input  logic               cfg_we,
    input  logic               cfg_index,
    input  logic [8:0]         cfg_data,
    output logic signed [39:0] sample_result,
    output logic               done
);

    // configured image size
    logic [8:0] height_reg;
    logic [8:0] width_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            height_reg <= 9'd256;
            width_reg  <= 9'd256;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_HEIGHT: height_reg <= cfg_data;
                CFG_WIDTH:  width_reg  <= cfg_data;
                default:    height_reg <= height_reg;
            endcase
        end
    end

    cmd_t front_cmd;
    cmd_t head_cmd;
    logic q_full;
    logic q_empty;
    logic q_pop;
    logic q_push;

    // a request enters the queue as soon as it is taken
    assign q_push = start && !q_full;
    assign busy   = q_full;

    cbs_front u_front
    (
        .action      (action),
        .pixel_row   (pixel_row),
        .pixel_col   (pixel_col),
        .pixel_value (pixel_value),
        .query_row   (query_row),
        .query_col   (query_col),
        .cmd         (front_cmd)
    );

    cbs_cmd_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (q_push),
        .push_cmd (front_cmd),
        .pop      (q_pop),
        .head     (head_cmd),
        .full     (q_full),
        .empty    (q_empty)
    );

    // back end holds the pixel memory and computes each query
    cbs_back #(
        .MAX_ROWS (MAX_ROWS),
        .MAX_COLS (MAX_COLS)
    ) u_back
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .head          (head_cmd),
        .empty         (q_empty),
        .height        (height_reg),
        .width         (width_reg),
        .pop           (q_pop),
        .sample_result (sample_result),
        .done          (done)
    );

endmodule

FILE: rtl/cbs_checker.sv
// port-level checks of the sampler and their bind
module cbs_checker
(
    input logic clk,
    input logic rst_n,
    input logic start,
    input logic busy,
    input logic done
);

    // results come from whole queries and never back to back
    a_done_single : assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("result strobe in consecutive cycles");

    a_done_gap : assert property (@(posedge clk) disable iff (!rst_n)
        done |-> ##2 !done)
        else $error("results too close together");

    // the queue only fills by taking a request
    a_busy_rise : assert property (@(posedge clk) disable iff (!rst_n)
        $rose(busy) |-> $past(start))
        else $error("busy rose without a request");

endmodule

bind cubic_bspline_subpixel_sampler cbs_checker u_cbs_checker
(
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .done  (done)
);
